// ----- rtl/bss_pkg.sv -----
package bss_pkg;

  localparam int unsigned PatBytes = 16;
  localparam int unsigned PatW     = 8 * PatBytes;
  localparam int unsigned LenW     = 5;
  localparam int unsigned PosW     = 15;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } bss_cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } bss_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
  } bss_out_t;

  typedef struct packed {
    logic [PatW-1:0] pattern;
    logic [LenW-1:0] eff_len;
  } bss_cfg_t;

endpackage

// ----- rtl/bss_cfg_regs.sv -----
module bss_cfg_regs #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bss_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output bss_pkg::bss_cfg_t                 cfg_o
);

  logic [bss_pkg::CfgDataW-1:0] pat_low_q, pat_low_d;
  logic [bss_pkg::CfgDataW-1:0] pat_high_q, pat_high_d;
  logic [bss_pkg::LenW-1:0]     len_q, len_d;

  always_comb begin
    pat_low_d  = pat_low_q;
    pat_high_d = pat_high_q;
    len_d      = len_q;
    if (cfg_we_i) begin
      case (bss_pkg::bss_cfg_idx_e'(cfg_index_i))
        bss_pkg::CFG_PAT_LOW: begin
          pat_low_d = cfg_wdata_i;
        end
        bss_pkg::CFG_PAT_HIGH: begin
          pat_high_d = cfg_wdata_i;
        end
        bss_pkg::CFG_PAT_LEN: begin
          len_d = cfg_wdata_i[bss_pkg::LenW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      len_q      <= bss_pkg::LenW'(1);
    end else begin
      pat_low_q  <= pat_low_d;
      pat_high_q <= pat_high_d;
      len_q      <= len_d;
    end
  end

  always_comb begin
    cfg_o.pattern = {pat_high_q, pat_low_q};
    if (len_q == '0) begin
      cfg_o.eff_len = bss_pkg::LenW'(1);
    end else if (len_q > bss_pkg::LenW'(MAX_PATTERN)) begin
      cfg_o.eff_len = bss_pkg::LenW'(MAX_PATTERN);
    end else begin
      cfg_o.eff_len = len_q;
    end
  end

endmodule

// ----- rtl/bss_matcher.sv -----
module bss_matcher #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned MAX_ARRAY   = 32767
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bss_pkg::bss_in_t   in_i,
  input  bss_pkg::bss_cfg_t  cfg_i,
  output bss_pkg::bss_out_t  result_o
);

  logic [7:0]               win_q [MAX_PATTERN];
  logic [7:0]               win_d [MAX_PATTERN];
  logic [bss_pkg::PosW-1:0] count_q, count_d;
  logic                     seen_q, seen_d;
  logic [bss_pkg::PosW-1:0] start_q, start_d;

  logic                     below_max;
  logic [bss_pkg::PosW-1:0] taken;
  logic                     len_hit;
  logic                     all_eq;
  logic                     new_match;

  always_comb begin
    win_d[0] = in_i.data_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  // Each candidate length has its own fixed comparison; the configured length picks one.
  always_comb begin
    len_hit = 1'b0;
    all_eq  = 1'b1;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      all_eq = 1'b1;
      for (int j = 0; j < l; j++) begin
        all_eq = all_eq & (win_d[l-1-j] == cfg_i.pattern[8*j +: 8]);
      end
      if (bss_pkg::LenW'(l) == cfg_i.eff_len) begin
        len_hit = all_eq;
      end
    end
  end

  assign below_max = count_q < bss_pkg::PosW'(MAX_ARRAY);
  assign taken     = count_q + bss_pkg::PosW'(1);
  assign new_match = below_max && !seen_q && len_hit &&
                     (taken >= {{(bss_pkg::PosW-bss_pkg::LenW){1'b0}}, cfg_i.eff_len});

  always_comb begin
    seen_d  = seen_q;
    start_d = start_q;
    count_d = count_q;
    if (new_match) begin
      seen_d  = 1'b1;
      start_d = taken - {{(bss_pkg::PosW-bss_pkg::LenW){1'b0}}, cfg_i.eff_len};
    end
    if (below_max) begin
      count_d = taken;
    end
    result_o.found          = seen_d;
    result_o.match_position = seen_d ? start_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_q[i] <= '0;
      end
      count_q <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else if (step_i) begin
      if (in_i.last_byte) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_q[i] <= '0;
        end
        count_q <= '0;
        seen_q  <= 1'b0;
        start_q <= '0;
      end else begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_q[i] <= win_d[i];
        end
        count_q <= count_d;
        seen_q  <= seen_d;
        start_q <= start_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bss_pkg::PosW'(MAX_ARRAY))
    else $error("The byte count has passed its saturation limit.");

  a_first_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q && !(step_i && in_i.last_byte) |=> seen_q && $stable(start_q))
    else $error("The first match start changed within an array.");

  a_start_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> start_q < count_q)
    else $error("The match start lies beyond the bytes taken.");
`endif

endmodule

// ----- rtl/byte_substring_search_core.sv -----
// Channel  Direction  Signals                                 Transaction
// in       input      in_valid_i, in_stall_o, in_data_i       one array byte and last flag
// out      output     out_valid_o, out_stall_i, out_data_o    found flag and first start
// cfg      input      cfg_we_i, cfg_index_i, cfg_wdata_i      one register write
//
// One byte is taken every cycle unless the input is stalled; a final byte passes the byte
// register and then the result register before its result appears.
// The rate is set by the combinational parallel compare of all pattern lengths on the window.
// Reset clears the window, count, match state and both valid registers; the pattern resets
// to zero bytes with a length of one.
// A stalled result blocks only a final byte from leaving the byte register.
module byte_substring_search_core #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned MAX_ARRAY   = 32767
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bss_pkg::bss_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bss_pkg::bss_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bss_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  bss_pkg::bss_cfg_t cfg;
  bss_pkg::bss_in_t  in_q;
  logic              in_valid_q, in_valid_d;
  bss_pkg::bss_out_t out_q;
  bss_pkg::bss_out_t result;
  logic              out_valid_q, out_valid_d;
  logic              step;
  logic              emit;
  logic              in_take;

  bss_cfg_regs #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bss_matcher #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_ARRAY  (MAX_ARRAY)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .in_i    (in_q),
    .cfg_i   (cfg),
    .result_o(result)
  );

  assign in_stall_o  = in_valid_q && in_q.last_byte && out_valid_q && out_stall_i;
  assign step        = in_valid_q && !in_stall_o;
  assign emit        = step && in_q.last_byte;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !step);
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("A result overwrote one still waiting to be taken.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_q.last_byte)
    else $error("The input stalled without a final byte waiting.");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !result.found |=> out_data_o.match_position == '0)
    else $error("A not-found result carried a nonzero position.");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ArrayCap   = 32767;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 6;

  class search_scoreboard;
    logic [bss_pkg::PatW-1:0] pattern;
    logic [bss_pkg::LenW-1:0] pat_len;
    logic [7:0]               window [bss_pkg::PatBytes];
    int unsigned              byte_count;
    bit                       match_seen;
    logic [bss_pkg::PosW-1:0] first_start;
    bss_pkg::bss_out_t        expected_q [$];
    int unsigned              failures;

    function new();
      pattern  = '0;
      pat_len  = 5'd1;
      failures = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (window[k]) window[k] = 8'h00;
      byte_count  = 0;
      match_seen  = 1'b0;
      first_start = '0;
    endfunction

    function int unsigned active_length();
      int unsigned n;
      n = pat_len;
      if (n == 0) n = 1;
      if (n > bss_pkg::PatBytes) n = bss_pkg::PatBytes;
      return n;
    endfunction

    function void write_register(bss_pkg::bss_cfg_idx_e idx,
                                 logic [bss_pkg::CfgDataW-1:0] value);
      case (idx)
        bss_pkg::CFG_PAT_LOW:  pattern[63:0]   = value;
        bss_pkg::CFG_PAT_HIGH: pattern[127:64] = value;
        bss_pkg::CFG_PAT_LEN:  pat_len         = value[bss_pkg::LenW-1:0];
        default: ;
      endcase
    endfunction

    // Called for every accepted input transaction.
    function void note_input(bss_pkg::bss_in_t item);
      int unsigned       len, taken, j, k;
      bit                equal;
      bss_pkg::bss_out_t res;
      len = active_length();
      for (k = bss_pkg::PatBytes - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = item.data_byte;
      if (byte_count < ArrayCap) begin
        taken = byte_count + 1;
        if (taken >= len && !match_seen) begin
          equal = 1'b1;
          for (j = 0; j < len; j++) begin
            if (window[len - 1 - j] !== pattern[8 * j +: 8]) equal = 1'b0;
          end
          if (equal) begin
            match_seen  = 1'b1;
            first_start = bss_pkg::PosW'(taken - len);
          end
        end
        byte_count = taken;
      end
      if (item.last_byte) begin
        res.found          = match_seen;
        res.match_position = match_seen ? first_start : '0;
        expected_q.push_back(res);
        clear_stream();
      end
    endfunction

    function void check_result(bss_pkg::bss_out_t got);
      bss_pkg::bss_out_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: found %0d position %0d", got.found, got.match_position);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found || got.match_position !== want.match_position) begin
        failures++;
        if (failures <= 10) begin
          $display("result mismatch: expected found %0d position %0d, got found %0d position %0d",
                   want.found, want.match_position, got.found, got.match_position);
        end
      end
    endfunction
  endclass

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  bss_pkg::bss_in_t             in_data      = '0;
  logic                         in_stall;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  bss_pkg::bss_out_t            out_data;
  logic                         cfg_we       = 1'b0;
  logic [bss_pkg::CfgIdxW-1:0]  cfg_index    = '0;
  logic [bss_pkg::CfgDataW-1:0] cfg_wdata    = '0;
  int unsigned                  send_gap_pct = 0;
  int unsigned                  stall_pct    = 0;
  int unsigned                  cycle_count  = 0;
  search_scoreboard             sb;

  byte_substring_search_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[byte_substring_search_core] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, last_byte: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] low, high, input logic [4:0] len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= bss_pkg::CFG_PAT_LOW;
    cfg_wdata <= low;
    @(posedge clk);
    sb.write_register(bss_pkg::CFG_PAT_LOW, low);
    cfg_index <= bss_pkg::CFG_PAT_HIGH;
    cfg_wdata <= high;
    @(posedge clk);
    sb.write_register(bss_pkg::CFG_PAT_HIGH, high);
    cfg_index <= bss_pkg::CFG_PAT_LEN;
    cfg_wdata <= bss_pkg::CfgDataW'(len);
    @(posedge clk);
    sb.write_register(bss_pkg::CFG_PAT_LEN, bss_pkg::CfgDataW'(len));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0] low, high;
    logic [4:0]  len;
    case ($urandom_range(0, 5))
      0: len = 5'd1;
      1: len = 5'd16;
      2: len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 4))
      0: begin
        low  = '0;
        high = '0;
      end
      1: begin
        low  = '1;
        high = '1;
      end
      2: begin
        low  = ({$urandom, $urandom} & 64'h0101010101010101) | 64'h4040404040404040;
        high = ({$urandom, $urandom} & 64'h0101010101010101) | 64'h4040404040404040;
      end
      default: begin
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
      end
    endcase
    configure(low, high, len);
  endtask

  task automatic send_random_array(output int unsigned count);
    logic [7:0]  bytes_q [$];
    int unsigned len, n, at, i;
    len = sb.active_length();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 2 * len + 6);
    for (i = 0; i < n; i++) begin
      at = $urandom_range(0, len - 1);
      if ($urandom_range(0, 3) == 0) bytes_q.push_back(8'($urandom_range(0, 255)));
      else bytes_q.push_back(sb.pattern[8 * at +: 8]);
    end
    if (n >= len && $urandom_range(0, 2) != 0) begin
      at = $urandom_range(0, n - len);
      for (i = 0; i < len; i++) bytes_q[at + i] = sb.pattern[8 * i +: 8];
      if ($urandom_range(0, 3) == 0) begin
        bytes_q[at + $urandom_range(0, len - 1)] ^= 8'h01 << $urandom_range(0, 7);
      end
    end
    for (i = 0; i < n; i++) send_byte(bytes_q[i], i == n - 1);
    count = n;
  endtask

  initial begin
    int unsigned mode, sent, batch, n, i;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    configure('1, '1, 5'd31);
    for (i = 0; i < 16; i++) send_byte(8'hFF, i == 15);

    configure(64'h5A, '0, 5'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);

    configure(64'h030201, '0, 5'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);

    for (mode = 0; mode < 4; mode++) begin
      send_gap_pct = (mode == 1) ? 51 : (mode == 3) ? 31 : 0;
      stall_pct    = (mode == 2) ? 51 : (mode == 3) ? 31 : 0;
      sent = 0;
      while (sent < 360) begin
        random_config();
        batch = 0;
        while (batch < 60) begin
          send_random_array(n);
          batch += n;
        end
        sent += batch;
      end
    end

    wait_idle();
    if (sb.failures == 0) begin
      $display("[byte_substring_search_core] OK");
    end else begin
      $display("[byte_substring_search_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bss_pkg.sv
rtl/bss_cfg_regs.sv
rtl/bss_matcher.sv
rtl/byte_substring_search_core.sv
verif/tb_top.sv
